// File: src/whp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the WAV header parser.
// No dependencies; every other file imports this package.
package whp_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int OUT_TDATA_W     = 168;

  localparam logic [23:0] ID_FMT3 = 24'h666D74;
  localparam logic [31:0] ID_DATA = 32'h64617461;
  localparam logic [15:0] FMT_PCM = 16'd1;

  // RIFF and WAVE tags at offsets 0-3 and 8-11; offsets 4-7 are the RIFF size.
  localparam logic [7:0] HDR_TAG [12] = '{
    8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h57, 8'h41, 8'h56, 8'h45
  };

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_NO_FMT     = 3'd2,
    ST_NOT_PCM    = 3'd3,
    ST_BAD_FMT    = 3'd4,
    ST_NO_DATA    = 3'd5
  } whp_status_t;

  // One parsed file, handed from the byte parser to the result stage.
  typedef struct packed {
    whp_status_t status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bit_depth;
  } whp_job_t;

endpackage

// File: src/whp_front.sv
`timescale 1ns / 1ps
// Byte parser: header tag check, chunk walk, fmt and data capture.
// Depends on whp_pkg; pushes one whp_job_t per file on the last byte.
module whp_front import whp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output whp_job_t   job
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [32:0]            ncs_r, ncs_nxt;
  logic [63:0]            shift_r, shift_nxt;
  logic                   hdr_ok_r, hdr_ok_nxt;
  logic                   fmt_found_r, fmt_found_nxt;
  logic [4:0]             fmt_idx_r, fmt_idx_nxt;
  logic [15:0]            fmt_code_r, fmt_code_nxt;
  logic [15:0]            chan_r, chan_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [15:0]            depth_r, depth_nxt;
  logic                   data_found_r, data_found_nxt;
  logic [31:0]            doff_r, doff_nxt;
  logic [31:0]            dsize_r, dsize_nxt;

  logic [33:0] pos_ext;
  logic        hdr_hit;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [33:0] chunk_end;
  logic        short_file;
  whp_status_t status;

  assign pos_ext    = {{(34-OFFSET_BITS){1'b0}}, pos_r};
  assign shift_nxt  = {shift_r[55:0], in_byte};
  assign hdr_hit    = (pos_ext == ({1'b0, ncs_r} + 34'd7));
  assign chunk_id   = shift_nxt[63:32];
  assign chunk_size = {shift_nxt[7:0], shift_nxt[15:8], shift_nxt[23:16], shift_nxt[31:24]};
  assign chunk_end  = {1'b0, ncs_r} + 34'd8 + {2'b00, chunk_size};
  assign short_file = (pos_r < OFFSET_BITS'(11));

  always_comb begin
    fmt_idx_nxt    = fmt_idx_r;
    fmt_code_nxt   = fmt_code_r;
    chan_nxt       = chan_r;
    rate_nxt       = rate_r;
    depth_nxt      = depth_r;
    hdr_ok_nxt     = hdr_ok_r;
    fmt_found_nxt  = fmt_found_r;
    data_found_nxt = data_found_r;
    doff_nxt       = doff_r;
    dsize_nxt      = dsize_r;
    ncs_nxt        = ncs_r;

    // fmt body: the 16 bytes right after the fmt chunk header
    if (fmt_found_r && !fmt_idx_r[4]) begin
      fmt_idx_nxt = fmt_idx_r + 5'd1;
      case (fmt_idx_r[3:0])
        4'd0:    fmt_code_nxt[7:0]  = in_byte;
        4'd1:    fmt_code_nxt[15:8] = in_byte;
        4'd2:    chan_nxt[7:0]      = in_byte;
        4'd3:    chan_nxt[15:8]     = in_byte;
        4'd4:    rate_nxt[7:0]      = in_byte;
        4'd5:    rate_nxt[15:8]     = in_byte;
        4'd6:    rate_nxt[23:16]    = in_byte;
        4'd7:    rate_nxt[31:24]    = in_byte;
        4'd14:   depth_nxt[7:0]     = in_byte;
        4'd15:   depth_nxt[15:8]    = in_byte;
        default: ;
      endcase
    end

    // tag bytes; the RIFF size field is not checked
    if (pos_r < OFFSET_BITS'(12)) begin
      if ((pos_r < OFFSET_BITS'(4) || pos_r >= OFFSET_BITS'(8)) &&
          (HDR_TAG[pos_r[3:0]] != in_byte)) begin
        hdr_ok_nxt = 1'b0;
      end
    end

    // last byte of a chunk header: classify and advance to the next chunk
    if (hdr_hit) begin
      if (!fmt_found_r && chunk_id[31:8] == ID_FMT3) begin
        fmt_found_nxt = 1'b1;
        fmt_idx_nxt   = 5'd0;
      end
      if (!data_found_r && chunk_id == ID_DATA) begin
        data_found_nxt = 1'b1;
        doff_nxt       = ncs_r[31:0] + 32'd8;
        dsize_nxt      = chunk_size;
      end
      ncs_nxt = chunk_end[33] ? '1 : chunk_end[32:0];
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + OFFSET_BITS'(1);

    if (!hdr_ok_nxt || short_file) begin
      status = ST_BAD_HEADER;
    end else if (!fmt_found_nxt) begin
      status = ST_NO_FMT;
    end else if (fmt_code_nxt != FMT_PCM) begin
      status = ST_NOT_PCM;
    end else if (chan_nxt == 16'd0 || rate_nxt == 32'd0 || depth_nxt < 16'd8) begin
      status = ST_BAD_FMT;
    end else if (!data_found_nxt) begin
      status = ST_NO_DATA;
    end else begin
      status = ST_OK;
    end
  end

  assign push              = in_accept && in_last;
  assign job.status        = status;
  assign job.data_offset   = doff_nxt;
  assign job.data_size     = dsize_nxt;
  assign job.sample_rate   = rate_nxt;
  assign job.channel_count = chan_nxt;
  assign job.bit_depth     = depth_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r        <= '0;
      ncs_r        <= 33'd12;
      shift_r      <= '0;
      hdr_ok_r     <= 1'b1;
      fmt_found_r  <= 1'b0;
      fmt_idx_r    <= '0;
      fmt_code_r   <= '0;
      chan_r       <= '0;
      rate_r       <= '0;
      depth_r      <= '0;
      data_found_r <= 1'b0;
      doff_r       <= '0;
      dsize_r      <= '0;
    end else if (in_accept) begin
      pos_r        <= pos_nxt;
      ncs_r        <= ncs_nxt;
      shift_r      <= shift_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      fmt_found_r  <= fmt_found_nxt;
      fmt_idx_r    <= fmt_idx_nxt;
      fmt_code_r   <= fmt_code_nxt;
      chan_r       <= chan_nxt;
      rate_r       <= rate_nxt;
      depth_r      <= depth_nxt;
      data_found_r <= data_found_nxt;
      doff_r       <= doff_nxt;
      dsize_r      <= dsize_nxt;
    end
  end

endmodule

// File: src/whp_queue.sv
`timescale 1ns / 1ps
// Short job queue between the byte parser and the result stage.
// Depends on whp_pkg for whp_job_t.
module whp_queue import whp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  whp_job_t push_job,
  input  logic     pop,
  output logic     q_valid,
  output whp_job_t q_job,
  output logic     q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  whp_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full || pop) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// File: src/whp_back.sv
`timescale 1ns / 1ps
// Result stage: frame count by multiply then bit-serial divide, output register; error jobs skip both and carry zeros.
// Depends on whp_pkg; consumes whp_job_t from the job queue.
module whp_back import whp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  whp_job_t               q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t      state_r, state_nxt;
  logic        valid_r, valid_nxt;
  whp_status_t status_r, status_nxt;
  logic [31:0] doff_r, doff_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  logic [28:0] prod;
  logic [32:0] rem_sh;
  logic        ge;

  // bytes per sample times channels; two successive floor divisions equal one
  assign prod   = depth_r[15:3] * chan_r;
  assign rem_sh = {rem_r, frame_r[31]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign q_pop  = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    status_nxt = status_r;
    doff_nxt   = doff_r;
    dsize_nxt  = dsize_r;
    rate_nxt   = rate_r;
    chan_nxt   = chan_r;
    depth_nxt  = depth_r;
    frame_nxt  = frame_r;
    dvs_nxt    = dvs_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          status_nxt = q_job.status;
          frame_nxt  = '0;
          if (q_job.status == ST_OK) begin
            doff_nxt  = q_job.data_offset;
            dsize_nxt = q_job.data_size;
            rate_nxt  = q_job.sample_rate;
            chan_nxt  = q_job.channel_count;
            depth_nxt = q_job.bit_depth;
            state_nxt = S_MUL;
          end else begin
            doff_nxt  = '0;
            dsize_nxt = '0;
            rate_nxt  = '0;
            chan_nxt  = '0;
            depth_nxt = '0;
            valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        dvs_nxt   = {3'b000, prod};
        rem_nxt   = '0;
        frame_nxt = dsize_r;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle, dividend shifts through frame_r
        rem_nxt   = ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
        frame_nxt = {frame_r[30:0], ge};
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    doff_r   <= doff_nxt;
    dsize_r  <= dsize_nxt;
    rate_r   <= rate_nxt;
    chan_r   <= chan_nxt;
    depth_r  <= depth_nxt;
    frame_r  <= frame_nxt;
    dvs_r    <= dvs_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b00000, frame_r, depth_r, chan_r, rate_r, dsize_r, doff_r,
                       status_r};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && status_r != ST_OK |-> frame_r == '0 && doff_r == '0 && dsize_r == '0 &&
    rate_r == '0 && chan_r == '0 && depth_r == '0) else $error("error result not zeroed");
  a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dvs_r != '0) else $error("divide by zero");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == 5'd31 |=> state_r == S_OUT && valid_r)
    else $error("divide did not finish into output");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_MUL || state_r == S_OUT) else $error("pop lost");

endmodule

// File: src/wav_header_parser.sv
`timescale 1ns / 1ps
// WAV (RIFF/PCM) header parser top level: one byte per cycle in, one result per file.
// Throughput: one byte per cycle; in_tready drops only while the job queue is full.
// On a good file the result passes through the job queue, the multiply state and the
// bit-serial divider before out_tvalid; on an error it goes from the queue straight to out_tvalid.
// Reset: synchronous, active low; clears the parser state, the queue and the result stage.
module wav_header_parser import whp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] byte_in
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [34:3] data_offset, [66:35] data_size, [98:67] sample_rate,
  // [114:99] channel_count, [130:115] bit_depth, [162:131] frame_count, [167:163] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic     in_accept;
  logic     push;
  whp_job_t push_job;
  logic     q_valid;
  whp_job_t q_job;
  logic     q_pop;
  logic     q_full;

  // hold bytes off only when no room is left for a finished file
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  // front: parse every accepted byte, emit one job on the last byte
  whp_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .push     (push),
    .job      (push_job)
  );

  // decouple the byte path from the slow frame count division
  whp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_full  (q_full)
  );

  // back: compute frame count and present the result transaction
  whp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for wav_header_parser: streams WAV files byte by byte, predicts the
// per-file result in SystemVerilog and compares every result field. Depends on whp_pkg.
module tb_top import whp_pkg::*; ();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [31:0] RIFF_ID = 32'h52494646;  // "RIFF"
  localparam logic [31:0] WAVE_ID = 32'h57415645;  // "WAVE"
  localparam logic [31:0] FMT_ID  = 32'h666D7420;  // "fmt "
  localparam logic [31:0] JUNK_ID = 32'h4A554E4B;  // "JUNK"
  localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;
  localparam logic [32:0] START_MAX = 33'h1_FFFF_FFFF;

  // One result as the parser reports it.
  typedef struct packed {
    whp_status_t status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bit_depth;
    logic [31:0] frame_count;
  } wav_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'd0;  // [7:0] byte_in
  logic                   in_tlast   = 1'b0;  // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [2:0] status, [34:3] data_offset, [66:35] data_size, [98:67] sample_rate,
  // [114:99] channel_count, [130:115] bit_depth, [162:131] frame_count, [167:163] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  wav_header_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model state: one file in progress
  // ---------------------------------------------------------------------------
  logic [31:0] byte_pos;
  logic [32:0] chunk_start;
  logic [63:0] hdr_window;
  logic        tag_ok;
  logic        fmt_seen;
  logic [4:0]  fmt_idx;
  logic [15:0] fmt_code;
  logic [15:0] fmt_chan;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_depth;
  logic        data_seen;
  logic [31:0] data_off;
  logic [31:0] data_len;

  wav_result_t pending_results [$];
  logic [7:0]  file_bytes [$];

  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned files_sent  = 0;
  int unsigned burst_left  = 0;
  bit          valid_up    = 1'b0;
  bit          steady_feed = 1'b0;
  int unsigned hold_asked  = 0;

  task automatic wav_model_clear();
    byte_pos    = '0;
    chunk_start = 33'd12;
    hdr_window  = '0;
    tag_ok      = 1'b1;
    fmt_seen    = 1'b0;
    fmt_idx     = '0;
    fmt_code    = '0;
    fmt_chan    = '0;
    fmt_rate    = '0;
    fmt_depth   = '0;
    data_seen   = 1'b0;
    data_off    = '0;
    data_len    = '0;
  endtask

  // Advance the model by one byte; on the last byte of a file, produce its result.
  task automatic wav_predict_byte(input logic [7:0] b, input logic lst,
                                  output bit emits, output wav_result_t res);
    logic [31:0] id;
    logic [31:0] sz;
    logic [33:0] nxt;
    logic [32:0] cnt;
    logic [7:0]  tag;
    logic [31:0] bytes_per_sample;
    emits = 1'b0;
    res   = '0;

    // Fmt body bytes are taken in order, whatever the declared chunk size.
    if (fmt_seen && fmt_idx < 5'd16) begin
      case (fmt_idx)
        5'd0:  fmt_code[7:0]   = b;
        5'd1:  fmt_code[15:8]  = b;
        5'd2:  fmt_chan[7:0]   = b;
        5'd3:  fmt_chan[15:8]  = b;
        5'd4:  fmt_rate[7:0]   = b;
        5'd5:  fmt_rate[15:8]  = b;
        5'd6:  fmt_rate[23:16] = b;
        5'd7:  fmt_rate[31:24] = b;
        5'd14: fmt_depth[7:0]  = b;
        5'd15: fmt_depth[15:8] = b;
        default: ;
      endcase
      fmt_idx = fmt_idx + 5'd1;
    end

    // RIFF at 0-3 and WAVE at 8-11; the RIFF size in between is not checked.
    tag = (byte_pos < 32'd4) ? RIFF_ID[8 * (3 - byte_pos[1:0]) +: 8]
                             : WAVE_ID[8 * (3 - byte_pos[1:0]) +: 8];
    if (byte_pos < 32'd12 && (byte_pos < 32'd4 || byte_pos >= 32'd8) && b != tag)
      tag_ok = 1'b0;

    hdr_window = {hdr_window[55:0], b};

    // Last byte of a chunk header: decode id and little-endian size, then skip.
    if ({2'b00, byte_pos} == {1'b0, chunk_start} + 34'd7) begin
      id = hdr_window[63:32];
      sz = {hdr_window[7:0], hdr_window[15:8], hdr_window[23:16], hdr_window[31:24]};
      if (!fmt_seen && id[31:8] == ID_FMT3) begin
        fmt_seen = 1'b1;
        fmt_idx  = '0;
      end
      if (!data_seen && id == ID_DATA) begin
        data_seen = 1'b1;
        data_off  = chunk_start[31:0] + 32'd8;
        data_len  = sz;
      end
      nxt = {1'b0, chunk_start} + 34'd8 + {2'b00, sz};
      chunk_start = (nxt > {1'b0, START_MAX}) ? START_MAX : nxt[32:0];
    end

    cnt      = {1'b0, byte_pos} + 33'd1;
    byte_pos = (byte_pos == POS_MAX) ? POS_MAX : cnt[31:0];

    if (lst) begin
      emits = 1'b1;
      if (!tag_ok || cnt < 33'd12)
        res.status = ST_BAD_HEADER;
      else if (!fmt_seen)
        res.status = ST_NO_FMT;
      else if (fmt_code != FMT_PCM)
        res.status = ST_NOT_PCM;
      else if (fmt_chan == 16'd0 || fmt_rate == 32'd0 || fmt_depth < 16'd8)
        res.status = ST_BAD_FMT;
      else if (!data_seen)
        res.status = ST_NO_DATA;
      else
        res.status = ST_OK;
      // Error results carry zeros in every other field.
      if (res.status == ST_OK) begin
        bytes_per_sample  = {16'd0, fmt_depth} >> 3;
        res.data_offset   = data_off;
        res.data_size     = data_len;
        res.sample_rate   = fmt_rate;
        res.channel_count = fmt_chan;
        res.bit_depth     = fmt_depth;
        res.frame_count   = (data_len / bytes_per_sample) / {16'd0, fmt_chan};
      end
      wav_model_clear();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one transaction per byte, sent in bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic lst);
    bit          emits;
    wav_result_t res;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    valid_up   = 1'b1;
    do @(posedge clk); while (!in_tready);
    // The byte was taken at this edge: update the model and queue any result.
    wav_predict_byte(b, lst, emits, res);
    if (emits) pending_results.push_back(res);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (!steady_feed && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        valid_up   = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put_u16(input logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endtask

  // Chunk ids go out in text order, first character first.
  task automatic put_id(input logic [31:0] id);
    put_byte(id[31:24]);
    put_byte(id[23:16]);
    put_byte(id[15:8]);
    put_byte(id[7:0]);
  endtask

  task automatic put_riff_head();
    file_bytes.delete();
    put_id(RIFF_ID);
    put_u32($urandom);
    put_id(WAVE_ID);
  endtask

  task automatic put_fmt(input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] depth,
                         input logic [31:0] decl, input int unsigned extra);
    put_id(FMT_ID);
    put_u32(decl);
    put_u16(code);
    put_u16(ch);
    put_u32(rate);
    put_u32($urandom);       // byte rate, not used
    put_u16(16'($urandom));  // block align, not used
    put_u16(depth);
    repeat (extra) put_byte(8'($urandom));
  endtask

  task automatic put_data(input logic [31:0] sz, input int unsigned payload);
    put_id(ID_DATA);
    put_u32(sz);
    repeat (payload) put_byte(8'($urandom));
  endtask

  task automatic put_good_file(input logic [15:0] code, input logic [15:0] ch,
                               input logic [31:0] rate, input logic [15:0] depth,
                               input logic [31:0] sz);
    put_riff_head();
    put_fmt(code, ch, rate, depth, 32'd16, 0);
    put_data(sz, 2);
  endtask

  // Drop the input valid before idling, so the last byte is not taken again.
  task automatic wait_drained();
    if (valid_up) begin
      in_tvalid <= 1'b0;
      valid_up   = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, with an occasional long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned phase_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      // Switch between always ready, mostly ready and mostly stalled stretches.
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        phase_left <= $urandom_range(16, 96);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin : result_check
    wav_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status",        {29'd0, want.status},        {29'd0, out_tdata[2:0]});
        check_field("data_offset",   want.data_offset,            out_tdata[34:3]);
        check_field("data_size",     want.data_size,              out_tdata[66:35]);
        check_field("sample_rate",   want.sample_rate,            out_tdata[98:67]);
        check_field("channel_count", {16'd0, want.channel_count}, {16'd0, out_tdata[114:99]});
        check_field("bit_depth",     {16'd0, want.bit_depth},     {16'd0, out_tdata[130:115]});
        check_field("frame_count",   want.frame_count,            out_tdata[162:131]);
        check_field("padding",       32'd0,                       {27'd0, out_tdata[167:163]});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL wav_header_parser");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_header_checks();
    file_bytes.delete();
    put_byte(8'hFF);  // a file of one byte
    send_file();
    put_riff_head();
    void'(file_bytes.pop_back());  // eleven bytes: too short
    send_file();
    put_good_file(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'h1000);
    file_bytes[3] = 8'h58;  // RIFX
    send_file();
    put_good_file(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'h1000);
    file_bytes[11] = 8'h46;  // WAVF
    send_file();
    put_riff_head();  // exactly the twelve header bytes
    send_file();
  endtask

  task automatic test_status_codes();
    put_riff_head();
    put_data(32'h40, 4);
    send_file();
    put_good_file(16'd3, 16'd2, 32'd48000, 16'd32, 32'h800);
    send_file();
    put_good_file(FMT_PCM, 16'd0, 32'd48000, 16'd16, 32'h800);
    send_file();
    put_good_file(FMT_PCM, 16'd2, 32'd0, 16'd16, 32'h800);
    send_file();
    put_good_file(FMT_PCM, 16'd2, 32'd48000, 16'd7, 32'h800);
    send_file();
    put_riff_head();
    put_fmt(FMT_PCM, 16'd2, 32'd48000, 16'd16, 32'd16, 0);
    send_file();
    // Data header cut off by the end of the stream: not found.
    put_riff_head();
    put_fmt(FMT_PCM, 16'd2, 32'd48000, 16'd16, 32'd16, 0);
    put_id(ID_DATA);
    put_u16(16'h0010);
    send_file();
    // Fmt body cut short: the missing bytes read as zero.
    put_riff_head();
    put_id(FMT_ID);
    put_u32(32'd16);
    repeat (10) put_byte(8'($urandom));
    send_file();
    // Id "fmtX" still counts; the second fmt and data chunks are ignored.
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16, 0);
    file_bytes[15] = 8'h58;
    put_data(32'h2, 2);
    put_fmt(16'd3, 16'd4, 32'd96000, 16'd24, 32'd16, 0);
    put_data(32'h99, 1);
    send_file();
  endtask

  task automatic test_field_extremes();
    put_good_file(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_file();
    put_good_file(FMT_PCM, 16'd1, 32'd1, 16'd8, 32'd0);
    send_file();
    put_good_file(FMT_PCM, 16'd1, 32'd1, 16'd8, 32'hFFFF_FFFF);
    send_file();
    // Fmt declared as 8 bytes: the data header doubles as the rest of the fmt body.
    put_riff_head();
    put_id(FMT_ID);
    put_u32(32'd8);
    put_u16(FMT_PCM);
    put_u16(16'd2);
    put_u32(32'd44100);
    put_data(32'h0010_0400, 0);
    send_file();
    // Junk chunk with an odd size, then an empty data chunk ahead of fmt.
    put_riff_head();
    put_id(JUNK_ID);
    put_u32(32'd3);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_data(32'd0, 0);
    put_fmt(FMT_PCM, 16'd2, 32'd22050, 16'd24, 32'd18, 2);
    send_file();
  endtask

  task automatic build_random_file();
    int unsigned kind;
    int unsigned n;
    logic [15:0] code;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] depth;
    bit          data_first;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // Plain noise of random length.
      file_bytes.delete();
      n = $urandom_range(1, 40);
      repeat (n) put_byte(8'($urandom));
    end else begin
      code = FMT_PCM;
      if ($urandom_range(0, 7) == 0) code = 16'($urandom);
      ch = 16'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) ch = 16'($urandom);
      if ($urandom_range(0, 19) == 0) ch = 16'd0;
      rate = $urandom_range(8000, 192000);
      if ($urandom_range(0, 7) == 0) rate = $urandom;
      if ($urandom_range(0, 19) == 0) rate = 32'd0;
      depth = 16'(8 * $urandom_range(1, 4));
      if ($urandom_range(0, 5) == 0) depth = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) depth = 16'($urandom_range(0, 9));

      put_riff_head();
      repeat ($urandom_range(0, 2)) begin
        put_id($urandom);
        n = $urandom_range(0, 5);
        put_u32(n);
        repeat (n) put_byte(8'($urandom));
      end
      data_first = ($urandom_range(0, 4) == 0);
      if (data_first) begin
        n = $urandom_range(0, 3);
        put_data(n, n);
      end
      n = $urandom_range(0, 4);
      put_fmt(code, ch, rate, depth, 32'd16 + n, n);
      if (!data_first) put_data($urandom, $urandom_range(0, 4));

      // Break some files: flip one bit, or cut the stream short.
      if (kind == 1) begin
        n = $urandom_range(0, file_bytes.size() - 1);
        file_bytes[n] = file_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
      end else if (kind == 2) begin
        n = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
    end
  endtask

  task automatic test_random_files();
    int unsigned first_byte;
    int unsigned first_file;
    first_byte = bytes_sent;
    first_file = files_sent;
    while (bytes_sent - first_byte < 100 || files_sent - first_file < 2) begin
      build_random_file();
      send_file();
    end
  endtask

  // Hold off the result side while one-byte files arrive back to back, so the
  // result queue fills and the input stalls.
  task automatic test_output_backpressure();
    wait_drained();
    hold_asked++;
    steady_feed = 1'b1;
    repeat (12) begin
      file_bytes.delete();
      put_byte(8'($urandom));
      send_file();
    end
    put_good_file(FMT_PCM, 16'd2, 32'd44100, 16'd16, $urandom);
    send_file();
    steady_feed = 1'b0;
  endtask

  initial begin
    wav_model_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_checks();
    test_status_codes();
    test_field_extremes();
    test_random_files();
    test_output_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS wav_header_parser");
    end else begin
      $display("FAIL wav_header_parser");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/whp_pkg.sv
src/whp_front.sv
src/whp_queue.sv
src/whp_back.sv
src/wav_header_parser.sv
bench/tb_top.sv
